/* rtl/dlr_pkg.sv */
// shared constants, payload types and controller/datapath interface types
package dlr_pkg;

   localparam int COORD_BITS   = 10;
   localparam int FRAC_BITS    = 16;
   localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 1;
   localparam int CNT_BITS     = COORD_BITS + 1;
   localparam int QUO_BITS     = FRAC_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(QUO_BITS);
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST_STEP = DIV_CNT_BITS'(QUO_BITS - 1);

   // operation codes of an input beat
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   typedef struct packed {
      logic                  operation;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_READY,
      ST_DIVIDE,
      ST_FINISH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic div_first;
      logic div_finish;
      logic advance;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic line_active;
   } dp_status_type;

endpackage

/* rtl/dlr_datapath.sv */
// line set-up dividers, accumulators, pixel counter and output register
module dlr_datapath
   import dlr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   output rsp_payload_type rsp_payload
);

   logic signed [ACC_BITS-1:0] x_accum_ff, x_accum_in;
   logic signed [ACC_BITS-1:0] y_accum_ff, y_accum_in;
   logic signed [ACC_BITS-1:0] x_inc_ff, x_inc_in;
   logic signed [ACC_BITS-1:0] y_inc_ff, y_inc_in;
   logic [CNT_BITS-1:0]        pixels_left_ff, pixels_left_in;
   logic                       line_active_ff, line_active_in;
   logic [COORD_BITS-1:0]      steps_ff, steps_in;
   logic [COORD_BITS-1:0]      x_rem_ff, x_rem_in;
   logic [COORD_BITS-1:0]      y_rem_ff, y_rem_in;
   logic [QUO_BITS-1:0]        x_quo_ff, x_quo_in;
   logic [QUO_BITS-1:0]        y_quo_ff, y_quo_in;
   logic                       x_neg_ff, x_neg_in;
   logic                       y_neg_ff, y_neg_in;
   rsp_payload_type            rsp_ff, rsp_in;

   logic                  x_neg_load, y_neg_load;
   logic [COORD_BITS-1:0] x_mag, y_mag, steps_load;
   logic [COORD_BITS-1:0] x_rem_step, y_rem_step;
   logic                  x_bit, y_bit;
   logic                  last_pixel;

   // one restoring division step: the first step compares without a shift
   function automatic logic [COORD_BITS:0] div_step(
      input logic [COORD_BITS-1:0] rem,
      input logic [COORD_BITS-1:0] divisor,
      input logic                  first
   );
      logic [COORD_BITS:0] trial;
      logic [COORD_BITS:0] diff;
      logic                ge;
      trial = first ? {1'b0, rem} : {rem, 1'b0};
      ge    = trial >= {1'b0, divisor};
      diff  = trial - {1'b0, divisor};
      return ge ? {diff[COORD_BITS-1:0], 1'b1} : {trial[COORD_BITS-1:0], 1'b0};
   endfunction

   // signed fixed-point increment from magnitude quotient and sign
   function automatic logic signed [ACC_BITS-1:0] make_inc(
      input logic [QUO_BITS-1:0] quo,
      input logic                neg,
      input logic                zero
   );
      logic [ACC_BITS-1:0] ext;
      ext = {{(ACC_BITS-QUO_BITS){1'b0}}, quo};
      if (zero) begin
         return '0;
      end
      return neg ? -ext : ext;
   endfunction

   // endpoint differences as sign and magnitude
   always_comb begin
      x_neg_load = req_payload.x_end < req_payload.x_start;
      y_neg_load = req_payload.y_end < req_payload.y_start;
      x_mag      = x_neg_load ? req_payload.x_start - req_payload.x_end
                              : req_payload.x_end - req_payload.x_start;
      y_mag      = y_neg_load ? req_payload.y_start - req_payload.y_end
                              : req_payload.y_end - req_payload.y_start;
      steps_load = (x_mag > y_mag) ? x_mag : y_mag;
   end

   // division lanes, one quotient bit per cycle each
   always_comb begin
      {x_rem_step, x_bit} = div_step(x_rem_ff, steps_ff, cmd.div_first);
      {y_rem_step, y_bit} = div_step(y_rem_ff, steps_ff, cmd.div_first);
   end

   assign last_pixel = pixels_left_ff <= CNT_BITS'(1);

   // next-state logic
   always_comb begin
      x_accum_in     = x_accum_ff;
      y_accum_in     = y_accum_ff;
      x_inc_in       = x_inc_ff;
      y_inc_in       = y_inc_ff;
      pixels_left_in = pixels_left_ff;
      line_active_in = line_active_ff;
      steps_in       = steps_ff;
      x_rem_in       = x_rem_ff;
      y_rem_in       = y_rem_ff;
      x_quo_in       = x_quo_ff;
      y_quo_in       = y_quo_ff;
      x_neg_in       = x_neg_ff;
      y_neg_in       = y_neg_ff;
      rsp_in         = rsp_ff;
      if (cmd.load) begin
         x_accum_in     = {1'b0, req_payload.x_start, {FRAC_BITS{1'b0}}};
         y_accum_in     = {1'b0, req_payload.y_start, {FRAC_BITS{1'b0}}};
         steps_in       = steps_load;
         x_rem_in       = x_mag;
         y_rem_in       = y_mag;
         x_quo_in       = '0;
         y_quo_in       = '0;
         x_neg_in       = x_neg_load;
         y_neg_in       = y_neg_load;
         pixels_left_in = {1'b0, steps_load} + CNT_BITS'(1);
         line_active_in = 1'b1;
      end
      if (cmd.div_step) begin
         x_rem_in = x_rem_step;
         y_rem_in = y_rem_step;
         x_quo_in = {x_quo_ff[QUO_BITS-2:0], x_bit};
         y_quo_in = {y_quo_ff[QUO_BITS-2:0], y_bit};
      end
      if (cmd.div_finish) begin
         x_inc_in = make_inc(x_quo_ff, x_neg_ff, steps_ff == '0);
         y_inc_in = make_inc(y_quo_ff, y_neg_ff, steps_ff == '0);
      end
      if (cmd.advance) begin
         rsp_in.pixel_x = x_accum_ff[FRAC_BITS +: COORD_BITS];
         rsp_in.pixel_y = y_accum_ff[FRAC_BITS +: COORD_BITS];
         rsp_in.last    = last_pixel;
         x_accum_in     = x_accum_ff + x_inc_ff;
         y_accum_in     = y_accum_ff + y_inc_ff;
         if (last_pixel) begin
            pixels_left_in = '0;
            line_active_in = 1'b0;
         end else begin
            pixels_left_in = pixels_left_ff - CNT_BITS'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         pixels_left_ff <= '0;
         x_accum_ff     <= '0;
         y_accum_ff     <= '0;
         x_inc_ff       <= '0;
         y_inc_ff       <= '0;
      end else begin
         line_active_ff <= line_active_in;
         pixels_left_ff <= pixels_left_in;
         x_accum_ff     <= x_accum_in;
         y_accum_ff     <= y_accum_in;
         x_inc_ff       <= x_inc_in;
         y_inc_ff       <= y_inc_in;
      end
   end

   // divider and output payload registers
   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      x_rem_ff <= x_rem_in;
      y_rem_ff <= y_rem_in;
      x_quo_ff <= x_quo_in;
      y_quo_ff <= y_quo_in;
      x_neg_ff <= x_neg_in;
      y_neg_ff <= y_neg_in;
      rsp_ff   <= rsp_in;
   end

   assign status.line_active = line_active_ff;
   assign rsp_payload        = rsp_ff;

endmodule

/* rtl/dlr_ctrl.sv */
// controller: handshakes, divider sequencing and output valid
module dlr_ctrl
   import dlr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_operation,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type            state_ff, state_in;
   logic [DIV_CNT_BITS-1:0]   div_cnt_ff, div_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;
   logic                      req_beat;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_beat = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_READY: begin
            req_ready = out_free;
            if (req_beat) begin
               if (req_operation == OP_LOAD) begin
                  cmd.load   = 1'b1;
                  div_cnt_in = '0;
                  state_in   = ST_DIVIDE;
               end else if (status.line_active) begin
                  cmd.advance  = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = div_cnt_ff == '0;
            div_cnt_in    = div_cnt_ff + DIV_CNT_BITS'(1);
            if (div_cnt_ff == DIV_LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.div_finish = 1'b1;
            state_in       = ST_READY;
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/dda_line_rasterizer.sv */
// top level of the dda line rasterizer: controller plus datapath
// a next beat on an active line puts its pixel in the output register the cycle after;
// next beats are taken every cycle while the output register is free or being drained
// a load beat closes the input through the divide and finish states, in which the bit-serial
// restoring dividers form the two increments
// synchronous active-high reset: no line active, no output beat pending
module dda_line_rasterizer
   import dlr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing and handshakes
   dlr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_payload.operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // arithmetic and line state
   dlr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/dlr_checker.sv */
// port-level checker for the rasterizer and its bind
module dlr_checker
   import dlr_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // a stalled output beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled output beat changed");

   // reset leaves no output beat pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output beat pending after reset");

   // line set-up keeps the input closed in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.operation == OP_LOAD |=> !req_ready)
      else $error("input open during line set-up");

   // a load beat never produces an output beat: with none pending at the load, none is pending after it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.operation == OP_LOAD && !rsp_valid
      |=> !rsp_valid)
      else $error("output beat after load");

   // input is only taken when the output register can accept a pixel
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("input taken with output register blocked");

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
